### hw/rtl/scp3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp3d_pkg
// Widths and word types shared by the segment closest-points pipeline.
// ----------------------------------------------------------------------------
package scp3d_pkg;

	localparam int CW  = 32;             // coordinate width
	localparam int DFW = CW + 1;         // coordinate difference
	localparam int PW  = 2 * DFW;        // difference product
	localparam int DTW = PW + 2;         // dot product
	localparam int WW  = 2 * DTW + 1;    // dot-by-dot terms, determinant
	localparam int NMW = WW + DFW;       // interpolation numerator
	localparam int QB  = CW + 5;         // quotient bits kept before saturation
	localparam int RW  = NMW + QB + 2;   // divider remainder

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic signed [CW-1:0] a_start_x;
		logic signed [CW-1:0] a_start_y;
		logic signed [CW-1:0] a_start_z;
		logic signed [CW-1:0] a_end_x;
		logic signed [CW-1:0] a_end_y;
		logic signed [CW-1:0] a_end_z;
		logic signed [CW-1:0] b_start_x;
		logic signed [CW-1:0] b_start_y;
		logic signed [CW-1:0] b_start_z;
		logic signed [CW-1:0] b_end_x;
		logic signed [CW-1:0] b_end_y;
		logic signed [CW-1:0] b_end_z;
	} in_word_t;

	typedef struct packed {
		logic signed [CW-1:0] near_a_x;
		logic signed [CW-1:0] near_a_y;
		logic signed [CW-1:0] near_a_z;
		logic signed [CW-1:0] near_b_x;
		logic signed [CW-1:0] near_b_y;
		logic signed [CW-1:0] near_b_z;
	} out_word_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cpt_t;

	typedef struct packed {
		logic signed [DFW-1:0] x;
		logic signed [DFW-1:0] y;
		logic signed [DFW-1:0] z;
	} dvec_t;

	// point = base + round(n * dir / den)
	typedef struct packed {
		cpt_t                 base;
		dvec_t                dir;
		logic signed [WW-1:0] n;
		logic [WW-1:0]        den;
	} proj_t;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [RW-1:0] rem;
		logic [WW:0]   dd;
		coord_t        base;
	} div_in_t;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [QB-1:0] q;
		coord_t        base;
	} div_out_t;

endpackage

### hw/rtl/scp3d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp3d_front
// Differences, dot products, feature tests and selection of the projection.
// ----------------------------------------------------------------------------
module scp3d_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  scp3d_pkg::in_word_t in_word,
	output logic               out_vld,
	output scp3d_pkg::proj_t   pa,
	output scp3d_pkg::proj_t   pb
);
	import scp3d_pkg::*;

	localparam int NDOT = 11;
	localparam int NMUL = 14;
	localparam int HB   = DTW / 2;   // split point of a dot product
	localparam int LW   = HB + 1;    // half operand, signed
	localparam int PPW  = 2 * LW;    // half product
	// operands: u, v, w1, w2, w3, w4
	localparam int DL [NDOT] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
	localparam int DR [NDOT] = '{2, 2, 3, 3, 4, 4, 5, 5, 0, 1, 1};
	// dots: da1 db1 da2 db2 da3 db3 da4 db4 la lb uv
	localparam int ML [NMUL] = '{1, 0, 2, 3, 1, 0, 4, 5, 8, 10, 9, 10, 10, 8};
	localparam int MR [NMUL] = '{8, 10, 10, 8, 10, 9, 9, 10, 9, 10, 0, 1, 0, 1};

	logic signed [CW-1:0]  pt     [4][3];
	logic signed [CW-1:0]  pt_s1  [4][3];
	logic signed [CW-1:0]  pt_s2  [4][3];
	logic signed [CW-1:0]  pt_s3  [4][3];
	logic signed [CW-1:0]  pt_s4  [4][3];
	logic signed [CW-1:0]  pt_s5  [4][3];
	logic signed [DFW-1:0] op_s1  [6][3];
	logic signed [DFW-1:0] dir_s2 [2][3];
	logic signed [DFW-1:0] dir_s3 [2][3];
	logic signed [DFW-1:0] dir_s4 [2][3];
	logic signed [DFW-1:0] dir_s5 [2][3];
	logic signed [PW-1:0]  pr_s2  [NDOT][3];
	logic signed [DTW-1:0] dot_s3 [NDOT];
	logic signed [DTW-1:0] dot_s4 [NDOT];
	logic signed [DTW-1:0] dot_s5 [NDOT];
	logic signed [PPW-1:0] pp_s4  [NMUL][4];
	logic signed [WW-1:0]  mul_s5 [NMUL];
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	function automatic logic signed [LW-1:0] hi_part(input logic signed [DTW-1:0] x);
		return LW'(x >>> HB);
	endfunction

	function automatic logic signed [LW-1:0] lo_part(input logic signed [DTW-1:0] x);
		return signed'({1'b0, x[HB-1:0]});
	endfunction

	function automatic logic signed [PPW-1:0] smul(input logic signed [LW-1:0] a,
			input logic signed [LW-1:0] b);
		return PPW'(a) * PPW'(b);
	endfunction

	assign pt[0] = '{in_word.a_start_x, in_word.a_start_y, in_word.a_start_z};
	assign pt[1] = '{in_word.a_end_x, in_word.a_end_y, in_word.a_end_z};
	assign pt[2] = '{in_word.b_start_x, in_word.b_start_y, in_word.b_start_z};
	assign pt[3] = '{in_word.b_end_x, in_word.b_end_y, in_word.b_end_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			out_vld <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1 <= pt;
			pt_s2 <= pt_s1;
			pt_s3 <= pt_s2;
			pt_s4 <= pt_s3;
			pt_s5 <= pt_s4;
			for (int i = 0; i < 3; i++) begin
				op_s1[0][i] <= DFW'(pt[1][i]) - DFW'(pt[0][i]);
				op_s1[1][i] <= DFW'(pt[3][i]) - DFW'(pt[2][i]);
				op_s1[2][i] <= DFW'(pt[2][i]) - DFW'(pt[0][i]);
				op_s1[3][i] <= DFW'(pt[3][i]) - DFW'(pt[0][i]);
				op_s1[4][i] <= DFW'(pt[2][i]) - DFW'(pt[1][i]);
				op_s1[5][i] <= DFW'(pt[3][i]) - DFW'(pt[1][i]);
				dir_s2[0][i] <= op_s1[0][i];
				dir_s2[1][i] <= op_s1[1][i];
			end
			for (int k = 0; k < NDOT; k++) begin
				for (int i = 0; i < 3; i++) begin
					pr_s2[k][i] <= PW'(op_s1[DL[k]][i]) * PW'(op_s1[DR[k]][i]);
				end
				dot_s3[k] <= DTW'(pr_s2[k][0]) + DTW'(pr_s2[k][1]) + DTW'(pr_s2[k][2]);
			end
			dir_s3 <= dir_s2;
			dir_s4 <= dir_s3;
			dir_s5 <= dir_s4;
			dot_s4 <= dot_s3;
			dot_s5 <= dot_s4;
			// dot-by-dot products as four half products, summed a stage later
			for (int k = 0; k < NMUL; k++) begin
				pp_s4[k][0] <= smul(hi_part(dot_s3[ML[k]]), hi_part(dot_s3[MR[k]]));
				pp_s4[k][1] <= smul(hi_part(dot_s3[ML[k]]), lo_part(dot_s3[MR[k]]));
				pp_s4[k][2] <= smul(lo_part(dot_s3[ML[k]]), hi_part(dot_s3[MR[k]]));
				pp_s4[k][3] <= smul(lo_part(dot_s3[ML[k]]), lo_part(dot_s3[MR[k]]));
				mul_s5[k]   <= (WW'(pp_s4[k][0]) << (2 * HB)) + (WW'(pp_s4[k][1]) << HB) +
					(WW'(pp_s4[k][2]) << HB) + WW'(pp_s4[k][3]);
			end
		end
	end

	logic signed [WW-1:0] t5, t6, t7, t8, det, na, nb;
	logic signed [DTW-1:0] da1, db1, da2, db2, da3, db3, da4, db4, la, lb;
	cpt_t  ca1, ca2, cb1, cb2;
	dvec_t cu, cv;
	proj_t pa_c, pb_c;

	function automatic logic le0(input logic signed [DTW-1:0] x);
		return x[DTW-1] || (x == '0);
	endfunction

	always_comb begin
		da1 = dot_s5[0]; db1 = dot_s5[1]; da2 = dot_s5[2]; db2 = dot_s5[3];
		da3 = dot_s5[4]; db3 = dot_s5[5]; da4 = dot_s5[6]; db4 = dot_s5[7];
		la  = dot_s5[8]; lb  = dot_s5[9];
		t5  = mul_s5[0] - mul_s5[1];
		t6  = mul_s5[2] - mul_s5[3];
		t7  = mul_s5[4] - mul_s5[5];
		t8  = mul_s5[6] - mul_s5[7];
		det = mul_s5[8] - mul_s5[9];
		na  = mul_s5[10] - mul_s5[11];
		nb  = mul_s5[12] - mul_s5[13];
		ca1 = '{pt_s5[0][0], pt_s5[0][1], pt_s5[0][2]};
		ca2 = '{pt_s5[1][0], pt_s5[1][1], pt_s5[1][2]};
		cb1 = '{pt_s5[2][0], pt_s5[2][1], pt_s5[2][2]};
		cb2 = '{pt_s5[3][0], pt_s5[3][1], pt_s5[3][2]};
		cu  = '{dir_s5[0][0], dir_s5[0][1], dir_s5[0][2]};
		cv  = '{dir_s5[1][0], dir_s5[1][1], dir_s5[1][2]};
		pa_c.base = ca1;
		pa_c.dir  = cu;
		pa_c.n    = '0;
		pa_c.den  = WW'(1);
		pb_c.base = cb1;
		pb_c.dir  = cv;
		pb_c.n    = '0;
		pb_c.den  = WW'(1);
		if (le0(da1) && !db1[DTW-1]) begin
			// vertex a1-b1: defaults
		end else if (le0(da2) && le0(db2)) begin
			pb_c.base = cb2;
		end else if (!da3[DTW-1] && !db3[DTW-1]) begin
			pa_c.base = ca2;
		end else if (!da4[DTW-1] && le0(db4)) begin
			pa_c.base = ca2;
			pb_c.base = cb2;
		end else if (!da1[DTW-1] && le0(da3) && la != '0 && !t5[WW-1]) begin
			pa_c.n   = WW'(da1);
			pa_c.den = WW'(la);
		end else if (!da2[DTW-1] && le0(da4) && la != '0 && !t6[WW-1]) begin
			pa_c.n    = WW'(da2);
			pa_c.den  = WW'(la);
			pb_c.base = cb2;
		end else if (le0(db1) && !db2[DTW-1] && lb != '0 && !t7[WW-1]) begin
			pb_c.n   = -WW'(db1);
			pb_c.den = WW'(lb);
		end else if (le0(db3) && !db4[DTW-1] && lb != '0 && !t8[WW-1]) begin
			pa_c.base = ca2;
			pb_c.n    = -WW'(db3);
			pb_c.den  = WW'(lb);
		end else if (!det[WW-1] && det != '0) begin
			pa_c.n   = na;
			pa_c.den = det;
			pb_c.n   = nb;
			pb_c.den = det;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa <= pa_c;
			pb <= pb_c;
		end
	end

endmodule

### hw/rtl/scp3d_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp3d_scale
// Numerator products per axis and setup of the rounded division.
// ----------------------------------------------------------------------------
module scp3d_scale (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  scp3d_pkg::proj_t  p,
	output logic              out_vld,
	output scp3d_pkg::div_in_t d [3]
);
	import scp3d_pkg::*;

	localparam int LB  = 35;          // numerator limb
	localparam int LMW = LB + 1;      // limb, signed
	localparam int SPW = LMW + DFW;   // limb product

	logic signed [DFW-1:0] dir [3];
	logic signed [CW-1:0]  bs  [3];
	logic signed [LMW-1:0] nl  [4];
	logic signed [SPW-1:0] pp_s6   [3][4];
	logic signed [CW-1:0]  base_s6 [3];
	logic [WW-1:0]         den_s6;
	logic                  vld_s6;
	logic signed [NMW-1:0] num_s7  [3];
	logic signed [CW-1:0]  base_s7 [3];
	logic [WW-1:0]         den_s7;
	logic                  vld_s7;

	assign dir = '{p.dir.x, p.dir.y, p.dir.z};
	assign bs  = '{p.base.x, p.base.y, p.base.z};

	always_comb begin
		nl[0] = signed'({1'b0, p.n[LB-1:0]});
		nl[1] = signed'({1'b0, p.n[2*LB-1:LB]});
		nl[2] = signed'({1'b0, p.n[3*LB-1:2*LB]});
		nl[3] = LMW'(p.n >>> (3 * LB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s6  <= in_vld;
			vld_s7  <= vld_s6;
			out_vld <= vld_s7;
		end
	end

	logic [NMW-1:0] mag [3];
	logic [NMW:0]   m2  [3];
	logic [WW:0]    dd;

	always_comb begin
		dd = {den_s7, 1'b0};
		for (int i = 0; i < 3; i++) begin
			mag[i] = num_s7[i][NMW-1] ? NMW'(-num_s7[i]) : NMW'(num_s7[i]);
			m2[i]  = {mag[i], 1'b0} + (NMW+1)'(den_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= p.den;
			base_s6 <= bs;
			den_s7  <= den_s6;
			base_s7 <= base_s6;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) begin
					pp_s6[i][j] <= SPW'(nl[j]) * SPW'(dir[i]);
				end
				num_s7[i]  <= (NMW'(pp_s6[i][3]) << (3 * LB)) +
					(NMW'(pp_s6[i][2]) << (2 * LB)) +
					(NMW'(pp_s6[i][1]) << LB) + NMW'(pp_s6[i][0]);
				d[i].neg   <= num_s7[i][NMW-1];
				d[i].ovf   <= RW'(m2[i]) >= (RW'(dd) << QB);
				d[i].rem   <= RW'(m2[i]);
				d[i].dd    <= dd;
				d[i].base  <= base_s7[i];
			end
		end
	end

endmodule

### hw/rtl/scp3d_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp3d_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module scp3d_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  scp3d_pkg::div_in_t  din,
	output logic                out_vld,
	output scp3d_pkg::div_out_t dout
);
	import scp3d_pkg::*;

	typedef struct packed {
		logic          neg;
		logic          ovf;
		logic [RW-1:0] rem;
		logic [WW:0]   dd;
		logic [QB-1:0] q;
		coord_t        base;
	} div_st_t;

	div_st_t       st [QB+1];
	logic [QB-1:0] vld_q;

	always_comb begin
		st[0].neg  = din.neg;
		st[0].ovf  = din.ovf;
		st[0].rem  = din.rem;
		st[0].dd   = din.dd;
		st[0].q    = '0;
		st[0].base = din.base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[QB-2:0], in_vld};
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = QB - 1 - j;
		logic [RW-1:0] trial;
		div_st_t       nxt;
		always_comb begin
			trial = RW'(st[j].dd) << K;
			nxt   = st[j];
			if (st[j].rem >= trial) begin
				nxt.rem  = st[j].rem - trial;
				nxt.q[K] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st[j+1] <= nxt;
			end
		end
	end

	assign out_vld   = vld_q[QB-1];
	assign dout.neg  = st[QB].neg;
	assign dout.ovf  = st[QB].ovf;
	assign dout.q    = st[QB].q;
	assign dout.base = st[QB].base;

endmodule

### hw/rtl/segment_closest_points_3d_core.sv
`timescale 1ns / 1ps
// Pipeline: 6 front stages, 3 scaling stages, 37 divider stages and 1 output
// register between accepted input word and output word.
// Throughput: one word per cycle; the divider pipeline retires one quotient bit
// per stage. A held output word stalls the whole pipeline.
// Reset clears all valid bits; datapath registers are not reset.
// ----------------------------------------------------------------------------
// segment_closest_points_3d_core
// Closest points between two 3D segments, exact fixed point, saturated.
// ----------------------------------------------------------------------------
module segment_closest_points_3d_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  scp3d_pkg::in_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output scp3d_pkg::out_word_t rsp
);
	import scp3d_pkg::*;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	logic     en;
	logic     f_vld, sa_vld, sb_vld;
	proj_t    pa, pb;
	div_in_t  da [3];
	div_in_t  db [3];
	div_out_t qa [3];
	div_out_t qb [3];
	logic [5:0] dv;

	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	scp3d_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(req_valid), .in_word(req),
		.out_vld(f_vld), .pa(pa), .pb(pb)
	);

	scp3d_scale u_scale_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(f_vld), .p(pa),
		.out_vld(sa_vld), .d(da)
	);

	scp3d_scale u_scale_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(f_vld), .p(pb),
		.out_vld(sb_vld), .d(db)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		scp3d_div u_div_a (
			.clk(clk), .arst_n(arst_n), .en(en), .in_vld(sa_vld), .din(da[i]),
			.out_vld(dv[i]), .dout(qa[i])
		);
		scp3d_div u_div_b (
			.clk(clk), .arst_n(arst_n), .en(en), .in_vld(sb_vld), .din(db[i]),
			.out_vld(dv[3+i]), .dout(qb[i])
		);
	end

	function automatic coord_t finish(input div_out_t d);
		logic signed [CW+QB:0] qq;
		logic signed [CW+QB:0] s;
		qq = signed'((CW+QB+1)'(d.q));
		s  = (CW+QB+1)'(d.base) + (d.neg ? -qq : qq);
		if (d.ovf) begin
			return d.neg ? CMIN : CMAX;
		end else if (s > (CW+QB+1)'(CMAX)) begin
			return CMAX;
		end else if (s < (CW+QB+1)'(CMIN)) begin
			return CMIN;
		end
		return CW'(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= dv[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.near_a_x <= finish(qa[0]);
			rsp.near_a_y <= finish(qa[1]);
			rsp.near_a_z <= finish(qa[2]);
			rsp.near_b_x <= finish(qb[0]);
			rsp.near_b_y <= finish(qb[1]);
			rsp.near_b_z <= finish(qb[2]);
		end
	end

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dv == '0 || dv == '1)
		else $error("divider lanes out of step");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv[0] && qa[0].ovf |=> rsp.near_a_x == CMAX || rsp.near_a_x == CMIN)
		else $error("overflowed quotient not saturated");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without held output");

	a_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv[0] |=> rsp_valid)
		else $error("finished word lost before output");

endmodule

### bench/tb_segment_closest_points_3d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_closest_points_3d_core
// Drives segment pairs through the closest-points core under random sender
// gaps and receiver stalls, and checks every output word against an exact
// wide-integer prediction of the Voronoi feature tests.
// ----------------------------------------------------------------------------
module tb_segment_closest_points_3d_core;
	import scp3d_pkg::*;

	typedef logic signed [255:0] big_t;
	typedef struct packed {
		big_t x;
		big_t y;
		big_t z;
	} bvec_t;

	localparam int ONE        = 65536;
	localparam int N_RANDOM   = 1880;
	localparam int IDLE_LIMIT = 5000;
	localparam int MAXC       = 32'h7fffffff;
	localparam int MINC       = 32'h80000000;

	class closest_point_board;
		out_word_t expected_q[$];
		int        errors;
		int        words_in;
		int        words_out;

		function new();
			errors    = 0;
			words_in  = 0;
			words_out = 0;
		endfunction

		function big_t dot(bvec_t p, bvec_t q);
			return p.x * q.x + p.y * q.y + p.z * q.z;
		endfunction

		function bvec_t vsub(bvec_t p, bvec_t q);
			bvec_t r;
			r.x = p.x - q.x;
			r.y = p.y - q.y;
			r.z = p.z - q.z;
			return r;
		endfunction

		// round to nearest, halves away from zero, den > 0
		function big_t rdiv(big_t num, big_t den);
			big_t m;
			big_t q;
			m = (num < 0) ? -num : num;
			q = (2 * m + den) / (2 * den);
			return (num < 0) ? -q : q;
		endfunction

		function bvec_t interp(bvec_t base, big_t n, bvec_t d, big_t den);
			bvec_t r;
			r.x = base.x + rdiv(n * d.x, den);
			r.y = base.y + rdiv(n * d.y, den);
			r.z = base.z + rdiv(n * d.z, den);
			return r;
		endfunction

		function coord_t sat(big_t x);
			if (x > big_t'(MAXC))
				return coord_t'(MAXC);
			if (x < -big_t'(2) ** 31)
				return coord_t'(MINC);
			return coord_t'(x);
		endfunction

		function out_word_t closest_points(in_word_t w);
			bvec_t a1, a2, b1, b2, u, v, w1, w2, w3, w4, ra, rb;
			big_t da1, db1, da2, db2, da3, db3, da4, db4, la, lb, uv, det;
			out_word_t o;
			a1.x = w.a_start_x; a1.y = w.a_start_y; a1.z = w.a_start_z;
			a2.x = w.a_end_x;   a2.y = w.a_end_y;   a2.z = w.a_end_z;
			b1.x = w.b_start_x; b1.y = w.b_start_y; b1.z = w.b_start_z;
			b2.x = w.b_end_x;   b2.y = w.b_end_y;   b2.z = w.b_end_z;
			u  = vsub(a2, a1);
			v  = vsub(b2, b1);
			w1 = vsub(b1, a1);
			w2 = vsub(b2, a1);
			w3 = vsub(b1, a2);
			w4 = vsub(b2, a2);
			da1 = dot(u, w1); db1 = dot(v, w1);
			da2 = dot(u, w2); db2 = dot(v, w2);
			da3 = dot(u, w3); db3 = dot(v, w3);
			da4 = dot(u, w4); db4 = dot(v, w4);
			la = dot(u, u); lb = dot(v, v); uv = dot(u, v);
			det = la * lb - uv * uv;
			if (da1 <= 0 && db1 >= 0) begin
				ra = a1; rb = b1;
			end else if (da2 <= 0 && db2 <= 0) begin
				ra = a1; rb = b2;
			end else if (da3 >= 0 && db3 >= 0) begin
				ra = a2; rb = b1;
			end else if (da4 >= 0 && db4 <= 0) begin
				ra = a2; rb = b2;
			end else if (da1 >= 0 && da3 <= 0 && la != 0 && db1 * la - da1 * uv >= 0) begin
				ra = interp(a1, da1, u, la); rb = b1;
			end else if (da2 >= 0 && da4 <= 0 && la != 0 && da2 * uv - db2 * la >= 0) begin
				ra = interp(a1, da2, u, la); rb = b2;
			end else if (db1 <= 0 && db2 >= 0 && lb != 0 && db1 * uv - da1 * lb >= 0) begin
				ra = a1; rb = interp(b1, -db1, v, lb);
			end else if (db3 <= 0 && db4 >= 0 && lb != 0 && da3 * lb - db3 * uv >= 0) begin
				ra = a2; rb = interp(b1, -db3, v, lb);
			end else if (det <= 0) begin
				ra = a1; rb = b1;
			end else begin
				ra = interp(a1, lb * da1 - uv * db1, u, det);
				rb = interp(b1, uv * da1 - la * db1, v, det);
			end
			o.near_a_x = sat(ra.x); o.near_a_y = sat(ra.y); o.near_a_z = sat(ra.z);
			o.near_b_x = sat(rb.x); o.near_b_y = sat(rb.y); o.near_b_z = sat(rb.z);
			return o;
		endfunction

		function void note_input(in_word_t w);
			expected_q.push_back(closest_points(w));
			words_in++;
		endfunction

		function void cmp(string name, coord_t exp_v, coord_t act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(out_word_t act);
			out_word_t e;
			words_out++;
			if (expected_q.size() == 0) begin
				$error("output word with nothing expected");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("near_a_x", e.near_a_x, act.near_a_x);
			cmp("near_a_y", e.near_a_y, act.near_a_y);
			cmp("near_a_z", e.near_a_z, act.near_a_z);
			cmp("near_b_x", e.near_b_x, act.near_b_x);
			cmp("near_b_y", e.near_b_y, act.near_b_y);
			cmp("near_b_z", e.near_b_z, act.near_b_z);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	in_word_t   req;
	logic       rsp_valid;
	logic       rsp_stall;
	out_word_t  rsp;

	closest_point_board board;
	int unsigned cyc;
	int unsigned idle_cycles;
	int unsigned long_stall;

	segment_closest_points_3d_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// receiver: stall mode steps through four modes in turn
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_result(rsp);
		cyc <= cyc + 1;
		case ((cyc / 256) % 4)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 2) == 0);
			2: rsp_stall <= ((cyc % 5) < 2);
			default: begin
				if (long_stall != 0) begin
					long_stall <= long_stall - 1;
					rsp_stall  <= 1'b1;
				end else if ($urandom_range(0, 15) == 0) begin
					long_stall <= $urandom_range(1, 16);
					rsp_stall  <= 1'b1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("** segment_closest_points_3d_core: FAILED **");
			$finish;
		end
	end

	function in_word_t seg(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz, int dx, int dy, int dz);
		in_word_t w;
		w = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
		return w;
	endfunction

	function int rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return int'($urandom_range(0, 16)) - 8;
			2: return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
			default: return ($urandom_range(0, 1) ? MAXC : MINC) + int'($urandom_range(0, 64)) - 32;
		endcase
	endfunction

	function in_word_t rnd_word();
		in_word_t w;
		int mode;
		int kind;
		int k;
		mode = $urandom_range(0, 3);
		w = seg(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
			rnd_coord(mode), rnd_coord(mode), rnd_coord(mode));
		kind = $urandom_range(0, 9);
		k = int'($urandom_range(0, 6)) - 3;
		case (kind)
			0: begin
				w.b_start_x = w.a_end_x; w.b_start_y = w.a_end_y; w.b_start_z = w.a_end_z;
			end
			1: begin
				w.a_end_x = w.a_start_x; w.a_end_y = w.a_start_y; w.a_end_z = w.a_start_z;
			end
			2: begin
				w.b_end_x = w.b_start_x; w.b_end_y = w.b_start_y; w.b_end_z = w.b_start_z;
			end
			3: if (mode != 0 && mode != 3) begin
				// parallel: B direction is a multiple of A direction
				w.b_end_x = w.b_start_x + k * (w.a_end_x - w.a_start_x);
				w.b_end_y = w.b_start_y + k * (w.a_end_y - w.a_start_y);
				w.b_end_z = w.b_start_z + k * (w.a_end_z - w.a_start_z);
			end
			4: begin
				w.a_start_z = 0; w.a_end_z = 0; w.b_start_z = 0; w.b_end_z = 0;
			end
			default: ;
		endcase
		return w;
	endfunction

	task automatic send(in_word_t w);
		req       <= w;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		board.note_input(w);
	endtask

	task automatic send_burst(in_word_t w, inout int left);
		send(w);
		if (--left <= 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
		end
	endtask

	initial begin
		in_word_t directed[$];
		int left;
		int guard;
		board       = new();
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_stall   = 1'b0;
		cyc         = 0;
		idle_cycles = 0;
		long_stall  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(seg(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(seg(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
			MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
		directed.push_back(seg(MINC, MINC, MINC, MINC, MINC, MINC,
			MINC, MINC, MINC, MINC, MINC, MINC));
		directed.push_back(seg(MINC, MINC, MINC, MAXC, MAXC, MAXC,
			MAXC, MINC, 0, MINC, MAXC, 0));
		directed.push_back(seg(MINC, 0, MAXC, MAXC, 0, MINC,
			0, MINC, MINC, 0, MAXC, MAXC));
		// endpoint pairs
		directed.push_back(seg(0, 0, 0, -ONE, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0));
		directed.push_back(seg(0, 0, 0, -ONE, 0, 0, 2 * ONE, 0, 0, ONE, 0, 0));
		directed.push_back(seg(-ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0));
		directed.push_back(seg(-ONE, 0, 0, 0, 0, 0, 2 * ONE, 0, 0, ONE, 0, 0));
		// endpoint onto edge
		directed.push_back(seg(0, 0, 0, 4 * ONE, 0, 0, 2 * ONE, 3 * ONE, 0, 2 * ONE, 5 * ONE, 0));
		directed.push_back(seg(0, 0, 0, 4 * ONE, 0, 0, ONE, 5 * ONE, 0, 3, 3 * ONE, 0));
		directed.push_back(seg(2 * ONE, 3 * ONE, 0, 2 * ONE, 5 * ONE, 0, 0, 0, 0, 4 * ONE, 0, 0));
		directed.push_back(seg(ONE, 5 * ONE, 0, 3, 3 * ONE, 0, 0, 0, 0, 4 * ONE, 0, 0));
		// crossing edges, skew edges
		directed.push_back(seg(-ONE, 0, 0, ONE, 0, 0, 0, -ONE, ONE, 0, ONE, ONE));
		directed.push_back(seg(-3, 1, 0, 4, -2, 1, 1, -5, 7, -2, 6, -3));
		// parallel and degenerate
		directed.push_back(seg(0, 0, 0, 4 * ONE, 0, 0, ONE, ONE, 0, 3 * ONE, ONE, 0));
		directed.push_back(seg(0, 0, 0, 4 * ONE, 0, 0, 3 * ONE, ONE, 0, ONE, ONE, 0));
		directed.push_back(seg(5, 5, 5, 5, 5, 5, 0, 0, 0, 9, 1, 2));
		directed.push_back(seg(0, 0, 0, 9, 1, 2, 5, 5, 5, 5, 5, 5));
		directed.push_back(seg(7, -3, 2, 7, -3, 2, -1, 4, 0, -1, 4, 0));
		// rounding halves
		directed.push_back(seg(0, 0, 0, 2, 0, 0, 1, 1, 0, 1, 2, 0));
		directed.push_back(seg(0, 0, 0, -3, 1, 0, -1, 4, 0, -1, 9, 0));
		directed.push_back(seg(MINC, MINC, 0, MAXC, MAXC, 0, MINC, MAXC, 0, MAXC, MINC, 0));

		left = 5;
		foreach (directed[i])
			send_burst(directed[i], left);
		for (int n = 0; n < N_RANDOM; n++)
			send_burst(rnd_word(), left);
		req_valid <= 1'b0;

		guard = 0;
		while (board.expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		$display("covered %0d segment pairs (directed extremes, shared, degenerate,",
			board.words_in);
		$display("parallel and random), %0d output words checked", board.words_out);
		if (board.errors == 0 && board.expected_q.size() == 0) begin
			$display("** segment_closest_points_3d_core: PASSED **");
		end else begin
			if (board.expected_q.size() != 0)
				$error("%0d expected words never arrived", board.expected_q.size());
			$display("** segment_closest_points_3d_core: FAILED **");
		end
		$finish;
	end
endmodule

### sim.f
hw/rtl/scp3d_pkg.sv
hw/rtl/scp3d_front.sv
hw/rtl/scp3d_scale.sv
hw/rtl/scp3d_div.sv
hw/rtl/segment_closest_points_3d_core.sv
bench/tb_segment_closest_points_3d_core.sv
